[rtl/gha_pkg.sv]
`default_nettype none

package gha_pkg;

    // field widths of the transactions
    localparam int INDEX_W = 10;
    localparam int GEN_W   = 16;
    localparam int COUNT_W = 11;

    // defaults for the top level parameters
    localparam int SLOTS_DEFAULT    = 1024;
    localparam int GEN_BITS_DEFAULT = 16;

    // max_slots after reset
    localparam logic [COUNT_W-1:0] MAX_SLOTS_RESET = 11'd1024;

    // opcodes
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [INDEX_W-1:0] handle_index;
        logic [GEN_W-1:0]   handle_generation;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic [GEN_W-1:0]   result_generation;
        logic               success;
        logic [COUNT_W-1:0] live_count;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/gha_ram.sv]
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/generational_handle_allocator_top.sv]
// result: registered from the read step for a fresh-slot create, failed create, no-op or
// null/unissued handle; destroy and query pass a check step first, reuse create pop and bump
// accept: one transaction at a time, in_ready only while idle; the pace is set by the registered
// reads of the slot table and the chained stack-then-slot read on reuse
// a waiting result does not block the next accept; a stalled out_ready holds the next result back
// reset: counters and control clear at once, max_slots returns to 1024, tables need no clearing
`default_nettype none

module generational_handle_allocator_top #(
    parameter int SLOTS    = gha_pkg::SLOTS_DEFAULT,
    parameter int GEN_BITS = gha_pkg::GEN_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire gha_pkg::in_item_t             in_data,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output gha_pkg::out_item_t                 out_data,
    // max_slots register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gha_pkg::COUNT_W-1:0]   cfg_data
);

    import gha_pkg::*;

    // widths derived from the table size
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMPI_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int CMPG_W = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;
    localparam int SLOT_W = GEN_BITS + 1;

    // small sequencer around the slot table and the free stack
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_POP   = 5'b00100,
        ST_BUMP  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [GEN_W-1:0]     gen_reg, gen_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [CNT_W-1:0]     free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]     slots_used_reg, slots_used_next;
    logic [CNT_W-1:0]     live_total_reg, live_total_next;
    logic [COUNT_W-1:0]   max_slots_reg;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    // slot table: {live, generation}
    logic                 slot_we;
    logic [IDX_W-1:0]     slot_waddr;
    logic [SLOT_W-1:0]    slot_wdata;
    logic [IDX_W-1:0]     slot_raddr;
    logic [SLOT_W-1:0]    slot_rdata;

    // free stack of slot indexes
    logic                 stack_we;
    logic [IDX_W-1:0]     stack_waddr;
    logic [IDX_W-1:0]     stack_wdata;
    logic [IDX_W-1:0]     stack_raddr;
    logic [IDX_W-1:0]     stack_rdata;

    logic                 out_free;
    logic [IDX_W-1:0]     idx_mem;
    logic                 idx_ok;
    logic [LIM_W-1:0]     limit;
    logic                 fresh_ok;
    logic [CNT_W-1:0]     free_dec;
    logic [GEN_BITS-1:0]  gen_inc;
    logic [GEN_BITS-1:0]  gen_bump;
    logic                 hit;
    logic [CMPI_W-1:0]    used_wide;
    logic [CMPI_W-1:0]    slot_wide;
    logic [CMPG_W-1:0]    bump_wide;
    logic [LIM_W-1:0]     live_wide;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the result register is free, or empties this cycle
    assign out_free = !out_valid_reg || out_ready;

    // handle index into the tables; its slot is only checked when below slots_used with a nonzero generation
    assign idx_mem = IDX_W'(CMPI_W'(idx_reg));
    assign idx_ok  = (CMPI_W'(idx_reg) < CMPI_W'(slots_used_reg)) && (gen_reg != '0);

    // effective limit on fresh slots is min(max_slots, SLOTS)
    assign limit    = (LIM_W'(max_slots_reg) < LIM_W'(SLOTS)) ? LIM_W'(max_slots_reg)
                                                             : LIM_W'(SLOTS);
    assign fresh_ok = LIM_W'(slots_used_reg) < limit;

    // top of stack sits one below the depth
    assign free_dec    = free_depth_reg - CNT_W'(1);
    assign stack_raddr = free_dec[IDX_W-1:0];
    assign stack_waddr = free_depth_reg[IDX_W-1:0];
    assign stack_wdata = idx_mem;

    // generation bump that skips zero on wrap
    assign gen_inc  = slot_rdata[GEN_BITS-1:0] + GEN_BITS'(1);
    assign gen_bump = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    // live and same generation, compared at full width
    assign hit = slot_rdata[GEN_BITS]
              && (CMPG_W'(slot_rdata[GEN_BITS-1:0]) == CMPG_W'(gen_reg));

    // output-width views
    assign used_wide = CMPI_W'(slots_used_reg);
    assign slot_wide = CMPI_W'(slot_reg);
    assign bump_wide = CMPG_W'(gen_bump);

    // slot table read address follows the step that needs it
    always_comb
    begin
        case (state_reg)
            ST_POP:  slot_raddr = stack_rdata;
            ST_BUMP: slot_raddr = slot_reg;
            default: slot_raddr = idx_mem;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        gen_next        = gen_reg;
        slot_next       = slot_reg;
        free_depth_next = free_depth_reg;
        slots_used_next = slots_used_reg;
        live_total_next = live_total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        slot_we         = 1'b0;
        slot_waddr      = idx_mem;
        slot_wdata      = '0;
        stack_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    idx_next   = in_data.handle_index;
                    gen_next   = in_data.handle_generation;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (free_depth_reg != '0)
                        begin
                            // reuse: stack top is being read
                            state_next = ST_POP;
                        end
                        else if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            if (fresh_ok)
                            begin
                                slot_we         = 1'b1;
                                slot_waddr      = slots_used_reg[IDX_W-1:0];
                                slot_wdata      = {1'b1, GEN_BITS'(1)};
                                slots_used_next = slots_used_reg + CNT_W'(1);
                                live_total_next = live_total_reg + CNT_W'(1);
                                out_data_next.result_index      = used_wide[INDEX_W-1:0];
                                out_data_next.result_generation = GEN_W'(1);
                                out_data_next.success           = 1'b1;
                            end
                            else
                            begin
                                out_data_next.result_index      = '0;
                                out_data_next.result_generation = '0;
                                out_data_next.success           = 1'b0;
                            end
                            state_next = ST_IDLE;
                        end
                    end

                    OP_DESTROY, OP_QUERY:
                    begin
                        if (idx_ok)
                        begin
                            state_next = ST_CHECK;
                        end
                        else if (out_free)
                        begin
                            // null handle or a slot never handed out
                            out_valid_next                  = 1'b1;
                            out_data_next.result_index      = idx_reg;
                            out_data_next.result_generation = gen_reg;
                            out_data_next.success           = 1'b0;
                            state_next                      = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            out_valid_next                  = 1'b1;
                            out_data_next.result_index      = idx_reg;
                            out_data_next.result_generation = gen_reg;
                            out_data_next.success           = 1'b0;
                            state_next                      = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_POP:
            begin
                slot_next  = stack_rdata;
                state_next = ST_BUMP;
            end

            ST_BUMP:
            begin
                if (out_free)
                begin
                    slot_we         = 1'b1;
                    slot_waddr      = slot_reg;
                    slot_wdata      = {1'b1, gen_bump};
                    free_depth_next = free_dec;
                    live_total_next = live_total_reg + CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_data_next.result_index      = slot_wide[INDEX_W-1:0];
                    out_data_next.result_generation = bump_wide[GEN_W-1:0];
                    out_data_next.success           = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_CHECK:
            begin
                if (out_free)
                begin
                    if (hit && (op_reg == OP_DESTROY))
                    begin
                        // clear live, keep generation, push the slot while the stack has room
                        slot_we    = 1'b1;
                        slot_waddr = idx_mem;
                        slot_wdata = {1'b0, slot_rdata[GEN_BITS-1:0]};
                        if (free_depth_reg < CNT_W'(SLOTS))
                        begin
                            stack_we        = 1'b1;
                            free_depth_next = free_depth_reg + CNT_W'(1);
                        end
                        if (live_total_reg != '0)
                        begin
                            live_total_next = live_total_reg - CNT_W'(1);
                        end
                    end
                    out_valid_next                  = 1'b1;
                    out_data_next.result_index      = idx_reg;
                    out_data_next.result_generation = gen_reg;
                    out_data_next.success           = hit;
                    state_next                      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // every result carries the count after the item
        live_wide = LIM_W'(live_total_next);
        if (out_valid_next && !(out_valid_reg && !out_ready))
        begin
            out_data_next.live_count = live_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_depth_reg <= '0;
            slots_used_reg <= '0;
            live_total_reg <= '0;
            max_slots_reg  <= MAX_SLOTS_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            slots_used_reg <= slots_used_next;
            live_total_reg <= live_total_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_slots_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        gen_reg      <= gen_next;
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end

    gha_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

endmodule

`default_nettype wire
